/* hw/rtl/mpa_pkg.sv */
package mpa_pkg;

    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int POOL_W     = 4;
    localparam int INDEX_W    = 30;
    localparam int PROD_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int DIM_LIMIT  = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_POOL_WIDTH    = 3'd3,
        REG_POOL_HEIGHT   = 3'd4,
        REG_STRIDE_X      = 3'd5,
        REG_STRIDE_Y      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [DIM_W-1:0]  channel_count;
        logic [POOL_W-1:0] pool_width;
        logic [POOL_W-1:0] pool_height;
        logic [POOL_W-1:0] stride_x;
        logic [POOL_W-1:0] stride_y;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   row0;
        logic [POS_W-1:0]   col0;
        logic [POOL_W-1:0]  pool_w;
        logic [POOL_W-1:0]  pool_h;
        logic [INDEX_W-1:0] plane_base;
        logic               frame_end;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_INDEX,
        ST_HOLD
    } win_state_t;

endpackage

/* hw/rtl/mpa_ram.sv */
module mpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/mpa_raster.sv */
module mpa_raster #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_POOL  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpa_pkg::cfg_t                       cfg,
    input  logic                                restart,
    input  logic                                take,
    output logic                                emit,
    output mpa_pkg::job_t                       job,
    output logic [$clog2(MAX_POOL)-1:0]         start_slot,
    output logic [$clog2(MAX_POOL)
                  + $clog2((MAX_WIDTH < mpa_pkg::DIM_LIMIT)
                           ? MAX_WIDTH : mpa_pkg::DIM_LIMIT)-1:0] wr_addr,
    output logic [mpa_pkg::DIM_W-1:0]           width
);

    localparam int WLIM   = (MAX_WIDTH < mpa_pkg::DIM_LIMIT) ? MAX_WIDTH : mpa_pkg::DIM_LIMIT;
    localparam int COL_W  = $clog2(WLIM);
    localparam int SLOT_W = $clog2(MAX_POOL);
    localparam int DIM_W  = mpa_pkg::DIM_W;
    localparam int POS_W  = mpa_pkg::POS_W;
    localparam int POOL_W = mpa_pkg::POOL_W;
    localparam int IDX_W  = mpa_pkg::INDEX_W;
    localparam int PROD_W = mpa_pkg::PROD_W;

    localparam logic [DIM_W-1:0]    WLIM_V   = DIM_W'(WLIM);
    localparam logic [DIM_W-1:0]    DMAX_V   = DIM_W'(mpa_pkg::DIM_LIMIT);
    localparam logic [POOL_W:0]     PMAX_V   = (POOL_W+1)'(MAX_POOL);
    localparam logic [SLOT_W:0]     SLOTS_V  = (SLOT_W+1)'(MAX_POOL);
    localparam logic [SLOT_W-1:0]   SLOT_TOP = SLOT_W'(MAX_POOL - 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
        logic [POOL_W-1:0] r;
        if (v == '0)
            r = POOL_W'(1);
        else if ({1'b0, v} > PMAX_V)
            r = PMAX_V[POOL_W-1:0];
        else
            r = v;
        return r;
    endfunction

    logic [DIM_W-1:0]  w_eff, h_eff, c_eff;
    logic [POOL_W-1:0] pw, ph, sx, sy, ph_m1;

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  chan_reg, chan_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [POOL_W-1:0] col_phase_reg, col_phase_next;
    logic [POOL_W-1:0] row_phase_reg, row_phase_next;
    logic [IDX_W-1:0]  plane_base_reg, plane_base_next;
    logic [PROD_W-1:0] plane_size_reg;

    logic col_fit, row_fit, col_last, row_last, chan_last;
    logic [SLOT_W:0] slot_sum;

    always_comb
    begin
        w_eff = clamp_dim(cfg.frame_width, WLIM_V);
        h_eff = clamp_dim(cfg.frame_height, DMAX_V);
        c_eff = clamp_dim(cfg.channel_count, DMAX_V);
        pw    = clamp_pool(cfg.pool_width);
        ph    = clamp_pool(cfg.pool_height);
        sx    = clamp_pool(cfg.stride_x);
        sy    = clamp_pool(cfg.stride_y);
        ph_m1 = ph - POOL_W'(1);
    end

    assign col_fit   = (DIM_W'(col_reg) + DIM_W'(1)) >= DIM_W'(pw);
    assign row_fit   = (DIM_W'(row_reg) + DIM_W'(1)) >= DIM_W'(ph);
    assign col_last  = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign row_last  = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;
    assign chan_last = (DIM_W'(chan_reg) + DIM_W'(1)) >= c_eff;

    assign emit = col_fit && row_fit && (col_phase_reg == '0) && (row_phase_reg == '0);

    // A corner is the last one of its row when the next corner would fall past the edge.
    always_comb
    begin
        job.row0       = row_reg + POS_W'(1) - POS_W'(ph);
        job.col0       = col_reg + POS_W'(1) - POS_W'(pw);
        job.pool_w     = pw;
        job.pool_h     = ph;
        job.plane_base = plane_base_reg;
        job.frame_end  = chan_last
                         && ((DIM_W'(col_reg) + DIM_W'(sx)) >= w_eff)
                         && ((DIM_W'(row_reg) + DIM_W'(sy)) >= h_eff);
        slot_sum       = (SLOT_W+1)'(slot_reg) + SLOTS_V - (SLOT_W+1)'(ph_m1);
        if (slot_sum >= SLOTS_V)
            start_slot = SLOT_W'(slot_sum - SLOTS_V);
        else
            start_slot = SLOT_W'(slot_sum);
    end

    assign wr_addr = {slot_reg, col_reg[COL_W-1:0]};
    assign width   = w_eff;

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        chan_next       = chan_reg;
        slot_next       = slot_reg;
        col_phase_next  = col_phase_reg;
        row_phase_next  = row_phase_reg;
        plane_base_next = plane_base_reg;
        if (restart)
        begin
            col_next        = '0;
            row_next        = '0;
            chan_next       = '0;
            slot_next       = '0;
            col_phase_next  = '0;
            row_phase_next  = '0;
            plane_base_next = '0;
        end
        else if (take)
        begin
            if (col_fit)
                col_phase_next = ((col_phase_reg + POOL_W'(1)) >= sx)
                                 ? '0 : col_phase_reg + POOL_W'(1);
            if (col_last)
            begin
                col_next       = '0;
                col_phase_next = '0;
                if (row_fit)
                    row_phase_next = ((row_phase_reg + POOL_W'(1)) >= sy)
                                     ? '0 : row_phase_reg + POOL_W'(1);
                if (row_last)
                begin
                    row_next       = '0;
                    row_phase_next = '0;
                    slot_next      = '0;
                    if (chan_last)
                    begin
                        chan_next       = '0;
                        plane_base_next = '0;
                    end
                    else
                    begin
                        chan_next       = chan_reg + POS_W'(1);
                        plane_base_next = plane_base_reg + IDX_W'(plane_size_reg);
                    end
                end
                else
                begin
                    row_next  = row_reg + POS_W'(1);
                    slot_next = (slot_reg == SLOT_TOP) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            chan_reg       <= '0;
            slot_reg       <= '0;
            col_phase_reg  <= '0;
            row_phase_reg  <= '0;
            plane_base_reg <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            chan_reg       <= chan_next;
            slot_reg       <= slot_next;
            col_phase_reg  <= col_phase_next;
            row_phase_reg  <= row_phase_next;
            plane_base_reg <= plane_base_next;
        end
    end

    // Samples per plane, followed from the registers; only read at a plane boundary.
    always_ff @(posedge clk)
    begin
        plane_size_reg <= PROD_W'(w_eff) * PROD_W'(h_eff);
    end

endmodule

/* hw/rtl/mpa_window.sv */
module mpa_window #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_POOL    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  mpa_pkg::job_t                       job,
    input  logic [$clog2(MAX_POOL)-1:0]         start_slot,
    input  logic [mpa_pkg::DIM_W-1:0]           width,
    output logic                                ready,
    output logic                                rd_en,
    output logic [$clog2(MAX_POOL)
                  + $clog2((MAX_WIDTH < mpa_pkg::DIM_LIMIT)
                           ? MAX_WIDTH : mpa_pkg::DIM_LIMIT)-1:0] rd_addr,
    input  logic signed [SAMPLE_BITS-1:0]       rd_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       max_value,
    output logic [mpa_pkg::INDEX_W-1:0]         max_index,
    output logic                                frame_end
);

    localparam int WLIM   = (MAX_WIDTH < mpa_pkg::DIM_LIMIT) ? MAX_WIDTH : mpa_pkg::DIM_LIMIT;
    localparam int COL_W  = $clog2(WLIM);
    localparam int SLOT_W = $clog2(MAX_POOL);
    localparam int POS_W  = mpa_pkg::POS_W;
    localparam int POOL_W = mpa_pkg::POOL_W;
    localparam int IDX_W  = mpa_pkg::INDEX_W;
    localparam int PROD_W = mpa_pkg::PROD_W;
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(MAX_POOL - 1);

    mpa_pkg::win_state_t state_reg, state_next;
    mpa_pkg::job_t       job_reg, job_next;

    logic [SLOT_W-1:0]              slot_reg, slot_next;
    logic [POOL_W-1:0]              n_reg, n_next, m_reg, m_next;
    logic                           rvalid_reg, rvalid_next;
    logic [POOL_W-1:0]              rn_reg, rm_reg;
    logic                           first_reg, first_next;
    logic signed [SAMPLE_BITS-1:0]  best_reg, best_next;
    logic [POOL_W-1:0]              best_n_reg, best_n_next, best_m_reg, best_m_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]               index_reg, index_next;
    logic                           end_reg, end_next;

    logic [POS_W-1:0] rd_col, best_row;
    logic             load;

    assign rd_col   = job_reg.col0 + POS_W'(m_reg);
    assign rd_addr  = {slot_reg, rd_col[COL_W-1:0]};
    assign best_row = job_reg.row0 + POS_W'(best_n_reg);
    assign load     = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        slot_next      = slot_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        first_next     = first_reg;
        best_next      = best_reg;
        best_n_next    = best_n_reg;
        best_m_next    = best_m_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        index_next     = index_reg;
        end_next       = end_reg;
        ready          = 1'b0;
        rd_en          = 1'b0;
        rvalid_next    = 1'b0;

        // Read data arrives in the cycle after its address is issued; the first element seeds the maximum.
        if (rvalid_reg && (first_reg || (rd_data > best_reg)))
        begin
            best_next   = rd_data;
            best_n_next = rn_reg;
            best_m_next = rm_reg;
        end
        if (rvalid_reg)
            first_next = 1'b0;

        case (state_reg)
            mpa_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    job_next   = job;
                    slot_next  = start_slot;
                    n_next     = '0;
                    m_next     = '0;
                    first_next = 1'b1;
                    state_next = mpa_pkg::ST_SCAN;
                end
            end
            mpa_pkg::ST_SCAN:
            begin
                rd_en       = 1'b1;
                rvalid_next = 1'b1;
                if (m_reg == job_reg.pool_w - POOL_W'(1))
                begin
                    m_next    = '0;
                    n_next    = n_reg + POOL_W'(1);
                    slot_next = (slot_reg == SLOT_TOP) ? '0 : slot_reg + SLOT_W'(1);
                    if (n_reg == job_reg.pool_h - POOL_W'(1))
                        state_next = mpa_pkg::ST_DRAIN;
                end
                else
                begin
                    m_next = m_reg + POOL_W'(1);
                end
            end
            mpa_pkg::ST_DRAIN:
            begin
                state_next = mpa_pkg::ST_INDEX;
            end
            mpa_pkg::ST_INDEX:
            begin
                prod_next  = PROD_W'(width) * PROD_W'(best_row);
                state_next = mpa_pkg::ST_HOLD;
            end
            mpa_pkg::ST_HOLD:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    value_next     = best_reg;
                    index_next     = job_reg.plane_base + IDX_W'(prod_reg)
                                     + IDX_W'(job_reg.col0) + IDX_W'(best_m_reg);
                    end_next       = job_reg.frame_end;
                    state_next     = mpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpa_pkg::ST_IDLE;
            rvalid_reg    <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rvalid_reg    <= rvalid_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        slot_reg   <= slot_next;
        n_reg      <= n_next;
        m_reg      <= m_next;
        rn_reg     <= n_reg;
        rm_reg     <= m_reg;
        best_reg   <= best_next;
        best_n_reg <= best_n_next;
        best_m_reg <= best_m_next;
        prod_reg   <= prod_next;
        value_reg  <= value_next;
        index_reg  <= index_next;
        end_reg    <= end_next;
    end

    assign out_valid = out_valid_reg;
    assign max_value = value_reg;
    assign max_index = index_reg;
    assign frame_end = end_reg;

`ifndef SYNTHESIS
    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == mpa_pkg::ST_IDLE))
        else $error("window start while a window is in progress");

    a_read_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> $past(state_reg == mpa_pkg::ST_SCAN))
        else $error("read data marked valid without a read issued");

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpa_pkg::ST_SCAN)
        |-> (m_reg < job_reg.pool_w) && (n_reg < job_reg.pool_h))
        else $error("scan position outside the pooling window");

    a_hold_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpa_pkg::ST_HOLD) && load |=> out_valid_reg)
        else $error("finished window did not reach the output register");
`endif

endmodule

/* hw/rtl/max_pool_2d_argmax_top.sv */
// Streaming 2-D max pooling with argmax. Samples enter in raster order (column, then row,
// then channel) and are written into a line store memory holding the last MAX_POOL rows.
// A sample that does not close a pooling window is taken whenever the window reader is
// idle. A sample that closes a window keeps the input stalled until its result is loaded:
// the window is read back from the line store one entry per cycle through its single read
// port, then the flat index of the first maximum is formed with one multiply and one add
// stage. The result then sits in an output register, so the next sample can enter while it
// waits; a window that finishes while the previous result is still waiting holds the input
// until that result is taken.
// Any register write restarts the frame at column, row and channel zero; write registers
// only while no transaction is in flight.
module max_pool_2d_argmax_top #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_POOL    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       max_value,
    output logic [mpa_pkg::INDEX_W-1:0]         max_index,
    output logic                                frame_end
);

    localparam int WLIM   = (MAX_WIDTH < mpa_pkg::DIM_LIMIT) ? MAX_WIDTH : mpa_pkg::DIM_LIMIT;
    localparam int COL_W  = $clog2(WLIM);
    localparam int SLOT_W = $clog2(MAX_POOL);
    localparam int AW     = SLOT_W + COL_W;
    localparam int DEPTH  = MAX_POOL * (2 ** COL_W);
    localparam int POOL_W = mpa_pkg::POOL_W;
    localparam int DIM_W  = mpa_pkg::DIM_W;

    mpa_pkg::cfg_t cfg_reg, cfg_next;
    logic          restart;

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_write)
        begin
            restart = 1'b1;
            case (cfg_index)
                mpa_pkg::REG_FRAME_WIDTH:   cfg_next.frame_width   = cfg_data;
                mpa_pkg::REG_FRAME_HEIGHT:  cfg_next.frame_height  = cfg_data;
                mpa_pkg::REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_data;
                mpa_pkg::REG_POOL_WIDTH:    cfg_next.pool_width    = cfg_data[POOL_W-1:0];
                mpa_pkg::REG_POOL_HEIGHT:   cfg_next.pool_height   = cfg_data[POOL_W-1:0];
                mpa_pkg::REG_STRIDE_X:      cfg_next.stride_x      = cfg_data[POOL_W-1:0];
                mpa_pkg::REG_STRIDE_Y:      cfg_next.stride_y      = cfg_data[POOL_W-1:0];
                default:                    restart                = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= DIM_W'(1);
            cfg_reg.frame_height  <= DIM_W'(1);
            cfg_reg.channel_count <= DIM_W'(1);
            cfg_reg.pool_width    <= POOL_W'(2);
            cfg_reg.pool_height   <= POOL_W'(2);
            cfg_reg.stride_x      <= POOL_W'(2);
            cfg_reg.stride_y      <= POOL_W'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    logic                    take, emit, start, win_ready, rd_en;
    mpa_pkg::job_t           job;
    logic [SLOT_W-1:0]       start_slot;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [DIM_W-1:0]        width;
    logic [SAMPLE_BITS-1:0]  rd_data;

    assign in_ready = win_ready;
    assign take     = in_valid && in_ready;
    assign start    = take && emit;

    mpa_raster #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_POOL  (MAX_POOL)
    ) u_raster (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .restart    (restart),
        .take       (take),
        .emit       (emit),
        .job        (job),
        .start_slot (start_slot),
        .wr_addr    (wr_addr),
        .width      (width)
    );

    mpa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (take),
        .waddr (wr_addr),
        .wdata (sample),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mpa_window #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_POOL    (MAX_POOL),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .job        (job),
        .start_slot (start_slot),
        .width      (width),
        .ready      (win_ready),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .max_value  (max_value),
        .max_index  (max_index),
        .frame_end  (frame_end)
    );

endmodule
